@@ design/iebus_pkg.sv @@
// ----------------------------------------------------------------------------
// iebus_pkg
// Shared codes, widths and the result record of the IEBus frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package iebus_pkg;

	// Field widths
	localparam int unsigned TickW = 12;
	localparam int unsigned AddrW = 12;
	localparam int unsigned ByteW = 8;
	localparam int unsigned CodeW = 3;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 12;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_OWN_ADDRESS = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_BIT_ZERO_MIN = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_START_MIN = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH = 2'd3;

	// Configuration reset values
	localparam logic [AddrW-1:0] OWN_ADDRESS_RST = 12'd0;
	localparam logic [TickW-1:0] BIT_ZERO_MIN_RST = 12'd26;
	localparam logic [TickW-1:0] START_MIN_RST = 12'd150;
	localparam logic [ByteW-1:0] MAX_LENGTH_RST = 8'd32;

	// Event codes
	localparam logic [CodeW-1:0] EV_ADDR = 3'd0;
	localparam logic [CodeW-1:0] EV_CTRL = 3'd1;
	localparam logic [CodeW-1:0] EV_LEN = 3'd2;
	localparam logic [CodeW-1:0] EV_DATA = 3'd3;
	localparam logic [CodeW-1:0] EV_END = 3'd4;
	localparam logic [CodeW-1:0] EV_ERR = 3'd5;

	// Error codes
	localparam logic [CodeW-1:0] ERR_NONE = 3'd0;
	localparam logic [CodeW-1:0] ERR_START = 3'd0;
	localparam logic [CodeW-1:0] ERR_MASTER_PAR = 3'd1;
	localparam logic [CodeW-1:0] ERR_SLAVE_PAR = 3'd2;
	localparam logic [CodeW-1:0] ERR_CTRL_PAR = 3'd3;
	localparam logic [CodeW-1:0] ERR_LEN_PAR = 3'd4;
	localparam logic [CodeW-1:0] ERR_TOO_LONG = 3'd5;
	localparam logic [CodeW-1:0] ERR_DATA_PAR = 3'd6;

	// One result item
	typedef struct packed {
		logic [CodeW-1:0] event_res;
		logic [CodeW-1:0] error_code;
		logic             is_broadcast_bit;
		logic [AddrW-1:0] master_addr;
		logic [AddrW-1:0] slave_addr;
		logic             addressed_to_me;
		logic [ByteW-1:0] payload_length;
		logic [ByteW-1:0] data_value;
		logic [ByteW-1:0] data_index;
		logic             ack_next;
	} result_t;

endpackage

`default_nettype wire

@@ design/iebus_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// iebus_frame_receiver
// Decodes measured bus pulses into IEBus frame fields, checks parity and
// length, and flags frames addressed to this node.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake               Payload
//  in       in   in_valid / in_stall     pulse_ticks
//  out      out  out_valid / out_stall   event_res .. ack_next (ten fields)
//  cfg      in   cfg_write_en            cfg_index, cfg_data
//
//  One pulse per cycle while in_stall is low; each pulse updates the frame
//  state in the cycle it is transferred; its result, if any, is registered in
//  the output register, or in the skid register behind it, which absorbs one
//  result while out stalls; in_stall is raised only while the skid is full.
//  Reset returns the decoder to idle and loads the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module iebus_frame_receiver
	import iebus_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// pulse input
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [TickW-1:0]    pulse_ticks,
	// result output
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [CodeW-1:0]         event_res,
	output logic [CodeW-1:0]         error_code,
	output logic                     is_broadcast_bit,
	output logic [AddrW-1:0]         master_addr,
	output logic [AddrW-1:0]         slave_addr,
	output logic                     addressed_to_me,
	output logic [ByteW-1:0]         payload_length,
	output logic [ByteW-1:0]         data_value,
	output logic [ByteW-1:0]         data_index,
	output logic                     ack_next,
	// configuration
	input  wire logic                cfg_write_en,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_BCAST  = 4'd1,
		PH_MASTER = 4'd2,
		PH_MPAR   = 4'd3,
		PH_SLAVE  = 4'd4,
		PH_SPAR   = 4'd5,
		PH_ACK_A  = 4'd6,
		PH_CTRL   = 4'd7,
		PH_CPAR   = 4'd8,
		PH_ACK_C  = 4'd9,
		PH_LEN    = 4'd10,
		PH_LPAR   = 4'd11,
		PH_ACK_L  = 4'd12,
		PH_DATA   = 4'd13,
		PH_DPAR   = 4'd14,
		PH_ACK_D  = 4'd15
	} phase_t;

	// configuration registers
	logic [AddrW-1:0] own_address_q;
	logic [TickW-1:0] bit_zero_min_q;
	logic [TickW-1:0] start_min_q;
	logic [ByteW-1:0] max_length_q;

	// frame state
	phase_t           phase_q, phase_d;
	logic [3:0]       bits_left_q, bits_left_d;
	logic [AddrW-1:0] shift_q, shift_d;
	logic             parity_q, parity_d;
	logic             mode_q, mode_d;
	logic [AddrW-1:0] master_q, master_d;
	logic [AddrW-1:0] slave_q, slave_d;
	logic             me_q, me_d;
	logic [ByteW-1:0] length_q, length_d;
	logic [ByteW-1:0] count_q, count_d;

	// result path
	logic             res_hit;
	logic [CodeW-1:0] res_ev;
	logic [CodeW-1:0] res_err;
	logic [ByteW-1:0] res_dval;
	logic [ByteW-1:0] res_didx;
	result_t          res_c;
	result_t          out_q, skid_q;
	logic             out_valid_q, skid_valid_q;

	logic in_xfer;
	logic out_xfer;
	logic rx_bit;
	logic [3:0] bits_dec;
	logic [ByteW-1:0] count_inc;

	assign in_stall = skid_valid_q;
	assign in_xfer  = in_valid & ~skid_valid_q;
	assign out_xfer = out_valid_q & ~out_stall;

	assign rx_bit    = (pulse_ticks < bit_zero_min_q);
	assign bits_dec  = bits_left_q - 4'd1;
	assign count_inc = count_q + 8'd1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q  <= OWN_ADDRESS_RST;
			bit_zero_min_q <= BIT_ZERO_MIN_RST;
			start_min_q    <= START_MIN_RST;
			max_length_q   <= MAX_LENGTH_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_OWN_ADDRESS:  own_address_q  <= cfg_data;
				CFG_BIT_ZERO_MIN: bit_zero_min_q <= cfg_data;
				CFG_START_MIN:    start_min_q    <= cfg_data;
				CFG_MAX_LENGTH:   max_length_q   <= cfg_data[ByteW-1:0];
				default: ;
			endcase
		end
	end

	// frame decode: next state and result for the pulse at the input
	always_comb begin
		phase_d     = phase_q;
		bits_left_d = bits_left_q;
		shift_d     = shift_q;
		parity_d    = parity_q;
		mode_d      = mode_q;
		master_d    = master_q;
		slave_d     = slave_q;
		me_d        = me_q;
		length_d    = length_q;
		count_d     = count_q;
		res_hit     = 1'b0;
		res_ev      = EV_ERR;
		res_err     = ERR_NONE;
		res_dval    = '0;
		res_didx    = '0;

		case (phase_q)
			PH_IDLE: begin
				if (pulse_ticks < start_min_q) begin
					res_hit = 1'b1;
					res_ev  = EV_ERR;
					res_err = ERR_START;
				end else begin
					mode_d   = 1'b0;
					master_d = '0;
					slave_d  = '0;
					me_d     = 1'b0;
					length_d = '0;
					count_d  = '0;
					phase_d  = PH_BCAST;
				end
			end
			PH_BCAST: begin
				mode_d      = rx_bit;
				phase_d     = PH_MASTER;
				bits_left_d = 4'd12;
				shift_d     = '0;
				parity_d    = 1'b0;
			end
			PH_MASTER, PH_SLAVE, PH_CTRL, PH_LEN, PH_DATA: begin
				shift_d     = {shift_q[AddrW-2:0], rx_bit};
				parity_d    = parity_q ^ rx_bit;
				bits_left_d = bits_dec;
				if (bits_dec == 4'd0)
					phase_d = phase_t'(phase_q + 4'd1);
			end
			PH_MPAR: begin
				if (rx_bit != parity_q) begin
					res_hit = 1'b1;
					res_err = ERR_MASTER_PAR;
					phase_d = PH_IDLE;
				end else begin
					master_d    = shift_q;
					phase_d     = PH_SLAVE;
					bits_left_d = 4'd12;
					shift_d     = '0;
					parity_d    = 1'b0;
				end
			end
			PH_SPAR: begin
				res_hit = 1'b1;
				if (rx_bit != parity_q) begin
					res_err = ERR_SLAVE_PAR;
					phase_d = PH_IDLE;
				end else begin
					slave_d = shift_q;
					me_d    = (shift_q == own_address_q);
					phase_d = PH_ACK_A;
					res_ev  = EV_ADDR;
				end
			end
			PH_ACK_A: begin
				phase_d     = PH_CTRL;
				bits_left_d = 4'd4;
				shift_d     = '0;
				parity_d    = 1'b0;
			end
			PH_CPAR: begin
				res_hit = 1'b1;
				if (rx_bit != parity_q) begin
					res_err = ERR_CTRL_PAR;
					phase_d = PH_IDLE;
				end else begin
					phase_d = PH_ACK_C;
					res_ev  = EV_CTRL;
				end
			end
			PH_ACK_C: begin
				phase_d     = PH_LEN;
				bits_left_d = 4'd8;
				shift_d     = '0;
				parity_d    = 1'b0;
			end
			PH_LPAR: begin
				res_hit = 1'b1;
				if (rx_bit != parity_q) begin
					res_err = ERR_LEN_PAR;
					phase_d = PH_IDLE;
				end else begin
					length_d = shift_q[ByteW-1:0];
					phase_d  = PH_ACK_L;
					res_ev   = EV_LEN;
				end
			end
			PH_ACK_L: begin
				if (length_q > max_length_q) begin
					res_hit = 1'b1;
					res_err = ERR_TOO_LONG;
					phase_d = PH_IDLE;
				end else if (length_q == '0) begin
					res_hit = 1'b1;
					res_ev  = EV_END;
					phase_d = PH_IDLE;
				end else begin
					phase_d     = PH_DATA;
					bits_left_d = 4'd8;
					shift_d     = '0;
					parity_d    = 1'b0;
				end
			end
			PH_DPAR: begin
				res_hit  = 1'b1;
				res_didx = count_q;
				if (rx_bit != parity_q) begin
					res_err = ERR_DATA_PAR;
					phase_d = PH_IDLE;
				end else begin
					phase_d  = PH_ACK_D;
					res_ev   = EV_DATA;
					res_dval = shift_q[ByteW-1:0];
				end
			end
			PH_ACK_D: begin
				count_d = count_inc;
				if (count_inc == length_q) begin
					res_hit = 1'b1;
					res_ev  = EV_END;
					phase_d = PH_IDLE;
				end else begin
					phase_d     = PH_DATA;
					bits_left_d = 4'd8;
					shift_d     = '0;
					parity_d    = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// result record built from the updated frame registers
	always_comb begin
		res_c.event_res        = res_ev;
		res_c.error_code       = res_err;
		res_c.is_broadcast_bit = mode_d;
		res_c.master_addr      = master_d;
		res_c.slave_addr       = slave_d;
		res_c.addressed_to_me  = me_d;
		res_c.payload_length   = length_d;
		res_c.data_value       = res_dval;
		res_c.data_index       = res_didx;
		res_c.ack_next         = (res_ev <= EV_DATA) ? me_d : 1'b0;
	end

	// frame state registers, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bits_left_q <= '0;
			shift_q     <= '0;
			parity_q    <= 1'b0;
			mode_q      <= 1'b0;
			master_q    <= '0;
			slave_q     <= '0;
			me_q        <= 1'b0;
			length_q    <= '0;
			count_q     <= '0;
		end else if (in_xfer) begin
			phase_q     <= phase_d;
			bits_left_q <= bits_left_d;
			shift_q     <= shift_d;
			parity_q    <= parity_d;
			mode_q      <= mode_d;
			master_q    <= master_d;
			slave_q     <= slave_d;
			me_q        <= me_d;
			length_q    <= length_d;
			count_q     <= count_d;
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_xfer) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer & res_hit;
			end
		end else if (in_xfer && res_hit) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_xfer) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_xfer && res_hit)
				out_q <= res_c;
		end else if (in_xfer && res_hit) begin
			skid_q <= res_c;
		end
	end

	assign out_valid        = out_valid_q;
	assign event_res        = out_q.event_res;
	assign error_code       = out_q.error_code;
	assign is_broadcast_bit = out_q.is_broadcast_bit;
	assign master_addr      = out_q.master_addr;
	assign slave_addr       = out_q.slave_addr;
	assign addressed_to_me  = out_q.addressed_to_me;
	assign payload_length   = out_q.payload_length;
	assign data_value       = out_q.data_value;
	assign data_index       = out_q.data_index;
	assign ack_next         = out_q.ack_next;

endmodule

`default_nettype wire

@@ bench/iebus_frame_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iebus_frame_checker
// Watches the pulse, result and register ports of the IEBus frame receiver.
// It decodes every transferred pulse with its own frame decoder, queues the
// result that pulse should cause, and compares each transferred result with
// the oldest queued one, field by field.
// ----------------------------------------------------------------------------

module iebus_frame_checker
	import iebus_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic [TickW-1:0]    pulse_ticks,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic [CodeW-1:0]    event_res,
	input  wire logic [CodeW-1:0]    error_code,
	input  wire logic                is_broadcast_bit,
	input  wire logic [AddrW-1:0]    master_addr,
	input  wire logic [AddrW-1:0]    slave_addr,
	input  wire logic                addressed_to_me,
	input  wire logic [ByteW-1:0]    payload_length,
	input  wire logic [ByteW-1:0]    data_value,
	input  wire logic [ByteW-1:0]    data_index,
	input  wire logic                ack_next,
	input  wire logic                cfg_write_en,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output int                       fail_count,
	output int                       pending,
	output int                       results_checked
);

	// Position inside a frame; field phases are followed by their parity phase
	typedef enum logic [3:0] {
		ST_IDLE, ST_BCAST, ST_MASTER, ST_MPAR, ST_SLAVE, ST_SPAR, ST_ACK_ADDR,
		ST_CTRL, ST_CPAR, ST_ACK_CTRL, ST_LEN, ST_LPAR, ST_ACK_LEN,
		ST_DATA, ST_DPAR, ST_ACK_DATA
	} rx_phase_e;

	// Register copies
	logic [AddrW-1:0] own_addr_q;
	logic [TickW-1:0] zero_min_q;
	logic [TickW-1:0] start_min_q;
	logic [ByteW-1:0] max_len_q;

	// Decoder state
	rx_phase_e        rx_phase;
	logic [3:0]       bits_left;
	logic [AddrW-1:0] shift_q;
	logic             parity_q;
	logic             mode_q;
	logic [AddrW-1:0] master_q;
	logic [AddrW-1:0] slave_q;
	logic             me_q;
	logic [ByteW-1:0] length_q;
	logic [ByteW-1:0] byte_cnt;

	result_t expected_events[$];

	// Result record carrying the current frame registers
	function automatic result_t frame_result(input logic [CodeW-1:0] ev,
			input logic [CodeW-1:0] code, input logic [ByteW-1:0] dval,
			input logic [ByteW-1:0] didx);
		result_t r;
		r.event_res        = ev;
		r.error_code       = code;
		r.is_broadcast_bit = mode_q;
		r.master_addr      = master_q;
		r.slave_addr       = slave_q;
		r.addressed_to_me  = me_q;
		r.payload_length   = length_q;
		r.data_value       = dval;
		r.data_index       = didx;
		r.ack_next         = (ev <= EV_DATA) ? me_q : 1'b0;
		return r;
	endfunction

	function automatic void open_field(input rx_phase_e nxt, input logic [3:0] nbits);
		rx_phase  = nxt;
		bits_left = nbits;
		shift_q   = '0;
		parity_q  = 1'b0;
	endfunction

	// Advances the decoder by one pulse; returns 1 when the pulse yields a result
	function automatic bit decode_pulse(input logic [TickW-1:0] ticks, output result_t res);
		logic bval;
		bval = (ticks < zero_min_q);
		res  = '0;
		case (rx_phase)
			ST_IDLE: begin
				if (ticks < start_min_q) begin
					res = frame_result(EV_ERR, ERR_START, '0, '0);
					return 1'b1;
				end
				mode_q   = 1'b0;
				master_q = '0;
				slave_q  = '0;
				me_q     = 1'b0;
				length_q = '0;
				byte_cnt = '0;
				rx_phase = ST_BCAST;
			end
			ST_BCAST: begin
				mode_q = bval;
				open_field(ST_MASTER, 4'd12);
			end
			ST_MASTER, ST_SLAVE, ST_CTRL, ST_LEN, ST_DATA: begin
				shift_q   = {shift_q[AddrW-2:0], bval};
				parity_q  = parity_q ^ bval;
				bits_left = bits_left - 4'd1;
				if (bits_left == 4'd0)
					rx_phase = rx_phase_e'(rx_phase + 4'd1);
			end
			ST_MPAR: begin
				if (bval != parity_q) begin
					rx_phase = ST_IDLE;
					res = frame_result(EV_ERR, ERR_MASTER_PAR, '0, '0);
					return 1'b1;
				end
				master_q = shift_q;
				open_field(ST_SLAVE, 4'd12);
			end
			ST_SPAR: begin
				if (bval != parity_q) begin
					rx_phase = ST_IDLE;
					res = frame_result(EV_ERR, ERR_SLAVE_PAR, '0, '0);
					return 1'b1;
				end
				slave_q  = shift_q;
				me_q     = (shift_q == own_addr_q);
				rx_phase = ST_ACK_ADDR;
				res = frame_result(EV_ADDR, ERR_NONE, '0, '0);
				return 1'b1;
			end
			ST_ACK_ADDR: open_field(ST_CTRL, 4'd4);
			ST_CPAR: begin
				if (bval != parity_q) begin
					rx_phase = ST_IDLE;
					res = frame_result(EV_ERR, ERR_CTRL_PAR, '0, '0);
					return 1'b1;
				end
				rx_phase = ST_ACK_CTRL;
				res = frame_result(EV_CTRL, ERR_NONE, '0, '0);
				return 1'b1;
			end
			ST_ACK_CTRL: open_field(ST_LEN, 4'd8);
			ST_LPAR: begin
				if (bval != parity_q) begin
					rx_phase = ST_IDLE;
					res = frame_result(EV_ERR, ERR_LEN_PAR, '0, '0);
					return 1'b1;
				end
				length_q = shift_q[ByteW-1:0];
				rx_phase = ST_ACK_LEN;
				res = frame_result(EV_LEN, ERR_NONE, '0, '0);
				return 1'b1;
			end
			ST_ACK_LEN: begin
				// length check lands on the ack slot that follows the length
				if (length_q > max_len_q) begin
					rx_phase = ST_IDLE;
					res = frame_result(EV_ERR, ERR_TOO_LONG, '0, '0);
					return 1'b1;
				end
				if (length_q == '0) begin
					rx_phase = ST_IDLE;
					res = frame_result(EV_END, ERR_NONE, '0, '0);
					return 1'b1;
				end
				open_field(ST_DATA, 4'd8);
			end
			ST_DPAR: begin
				if (bval != parity_q) begin
					rx_phase = ST_IDLE;
					res = frame_result(EV_ERR, ERR_DATA_PAR, '0, byte_cnt);
					return 1'b1;
				end
				rx_phase = ST_ACK_DATA;
				res = frame_result(EV_DATA, ERR_NONE, shift_q[ByteW-1:0], byte_cnt);
				return 1'b1;
			end
			default: begin
				// ack slot of a data byte; the last one closes the frame
				byte_cnt = byte_cnt + 8'd1;
				if (byte_cnt == length_q) begin
					rx_phase = ST_IDLE;
					res = frame_result(EV_END, ERR_NONE, '0, '0);
					return 1'b1;
				end
				open_field(ST_DATA, 4'd8);
			end
		endcase
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Transfers are sampled at the rising edge; results are retired before the
	// pulse of the same edge is decoded
	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		if (!arst_n) begin
			expected_events.delete();
			own_addr_q      = OWN_ADDRESS_RST;
			zero_min_q      = BIT_ZERO_MIN_RST;
			start_min_q     = START_MIN_RST;
			max_len_q       = MAX_LENGTH_RST;
			rx_phase        = ST_IDLE;
			bits_left       = '0;
			shift_q         = '0;
			parity_q        = 1'b0;
			mode_q          = 1'b0;
			master_q        = '0;
			slave_q         = '0;
			me_q            = 1'b0;
			length_q        = '0;
			byte_cnt        = '0;
			fail_count      = 0;
			pending         = 0;
			results_checked = 0;
		end else begin
			// result side
			if (out_valid && !out_stall) begin
				seen = '{event_res, error_code, is_broadcast_bit, master_addr, slave_addr,
					addressed_to_me, payload_length, data_value, data_index, ack_next};
				if (expected_events.size() == 0) begin
					fail_count++;
					$display("%0t: result transfer with none expected, event %0d",
						$time, event_res);
				end else begin
					want = expected_events.pop_front();
					check_field("event_res", 32'(want.event_res), 32'(seen.event_res));
					check_field("error_code", 32'(want.error_code),
						32'(seen.error_code));
					check_field("is_broadcast_bit", 32'(want.is_broadcast_bit),
						32'(seen.is_broadcast_bit));
					check_field("master_addr", 32'(want.master_addr),
						32'(seen.master_addr));
					check_field("slave_addr", 32'(want.slave_addr),
						32'(seen.slave_addr));
					check_field("addressed_to_me", 32'(want.addressed_to_me),
						32'(seen.addressed_to_me));
					check_field("payload_length", 32'(want.payload_length),
						32'(seen.payload_length));
					check_field("data_value", 32'(want.data_value),
						32'(seen.data_value));
					check_field("data_index", 32'(want.data_index),
						32'(seen.data_index));
					check_field("ack_next", 32'(want.ack_next), 32'(seen.ack_next));
					results_checked++;
				end
			end
			// register writes
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_OWN_ADDRESS:  own_addr_q  = cfg_data;
					CFG_BIT_ZERO_MIN: zero_min_q  = cfg_data;
					CFG_START_MIN:    start_min_q = cfg_data;
					default:          max_len_q   = cfg_data[ByteW-1:0];
				endcase
			end
			// pulse side
			if (in_valid && !in_stall) begin
				if (decode_pulse(pulse_ticks, want))
					expected_events.push_back(want);
			end
			pending = expected_events.size();
		end
	end

endmodule

@@ bench/tb_iebus_frame_receiver.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iebus_frame_receiver
// Drives measured bus pulses into the IEBus frame receiver: a few directed
// pulses, then mostly well-formed frames with random content under several
// register settings, mixed with parity errors, overlong lengths and noise.
// Both channels idle at random; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------

module tb_iebus_frame_receiver;
	import iebus_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [TickW-1:0]    pulse_ticks;
	logic                out_valid;
	logic                out_stall;
	logic [CodeW-1:0]    event_res;
	logic [CodeW-1:0]    error_code;
	logic                is_broadcast_bit;
	logic [AddrW-1:0]    master_addr;
	logic [AddrW-1:0]    slave_addr;
	logic                addressed_to_me;
	logic [ByteW-1:0]    payload_length;
	logic [ByteW-1:0]    data_value;
	logic [ByteW-1:0]    data_index;
	logic                ack_next;
	logic                cfg_write_en;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	int fail_count;
	int pending;
	int results_checked;

	// Stimulus-side view of the registers, used only to shape pulses
	logic [AddrW-1:0] cur_own;
	logic [TickW-1:0] cur_zero_min;
	logic [TickW-1:0] cur_start_min;
	logic [ByteW-1:0] cur_max_len;

	logic steady;
	int   holdoff_req;
	int   holdoff_seen;
	int   hold_left;
	int   pulses_sent;
	int   frames_sent;
	int   settings_done;

	iebus_frame_receiver DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pulse_ticks(pulse_ticks),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .error_code(error_code),
		.is_broadcast_bit(is_broadcast_bit), .master_addr(master_addr),
		.slave_addr(slave_addr), .addressed_to_me(addressed_to_me),
		.payload_length(payload_length), .data_value(data_value),
		.data_index(data_index), .ack_next(ack_next),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	iebus_frame_checker frame_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pulse_ticks(pulse_ticks),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .error_code(error_code),
		.is_broadcast_bit(is_broadcast_bit), .master_addr(master_addr),
		.slave_addr(slave_addr), .addressed_to_me(addressed_to_me),
		.payload_length(payload_length), .data_value(data_value),
		.data_index(data_index), .ack_next(ack_next),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .results_checked(results_checked)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#8_000_000;
		$display("Timeout with %0d results still expected", pending);
		$display("TEST FAILED");
		$finish;
	end

	// Result side: random stall, or a long hold-off when requested
	initial begin
		out_stall    = 1'b0;
		holdoff_seen = 0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (holdoff_req != holdoff_seen) begin
				holdoff_seen = holdoff_req;
				hold_left    = 120;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !steady && ($urandom_range(99, 0) < 19);
			end
		end
	end

	// One pulse transfer; entered and left just after a falling edge
	task automatic send_pulse(input logic [TickW-1:0] ticks);
		while (!steady && $urandom_range(99, 0) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		pulse_ticks <= ticks;
		do @(posedge clk); while (in_stall);
		pulses_sent++;
		@(negedge clk);
	endtask

	// Pulse that decodes to the given bit, often right at the threshold
	task automatic send_bit(input logic bval);
		int r;
		r = $urandom_range(3, 0);
		if (bval && cur_zero_min != '0)
			send_pulse((r == 0) ? cur_zero_min - 12'd1 : (r == 1) ? 12'd0 :
				12'($urandom_range(cur_zero_min - 1, 0)));
		else if (bval)
			send_pulse(12'($urandom_range(4095, 0)));
		else
			send_pulse((r == 0) ? cur_zero_min : (r == 1) ? 12'hFFF :
				12'($urandom_range(4095, cur_zero_min)));
	endtask

	// Field bits MSB first, then its even parity bit (inverted on request)
	task automatic send_field(input logic [11:0] value, input int width, input logic flip);
		logic par;
		int   i;
		par = flip;
		for (i = width - 1; i >= 0; i--) begin
			send_bit(value[i]);
			par = par ^ value[i];
		end
		send_bit(par);
	endtask

	// One frame; a parity error stops it at the bad field, an overlong length
	// stops it at the ack slot after the length
	task automatic send_frame(input logic [CodeW-1:0] err, input int len);
		logic [AddrW-1:0] master;
		logic [AddrW-1:0] slave;
		logic [3:0]       ctrl;
		logic [ByteW-1:0] dbyte;
		int               bad_byte;
		int               k;
		int               r;
		master   = 12'($urandom_range(4095, 0));
		slave    = ($urandom_range(99, 0) < 40) ? cur_own : 12'($urandom_range(4095, 0));
		ctrl     = 4'($urandom_range(15, 0));
		bad_byte = (len > 0) ? $urandom_range(len - 1, 0) : 0;
		// with no pulse decoding as 1, only all-zero fields are well formed
		if (cur_zero_min == '0) begin
			master = '0;
			slave  = '0;
			ctrl   = '0;
		end
		frames_sent++;
		r = $urandom_range(3, 0);
		send_pulse((r == 0) ? cur_start_min : (r == 1) ? 12'hFFF :
			12'($urandom_range(4095, cur_start_min)));
		send_bit(1'($urandom_range(1, 0)));
		send_field(master, 12, err == ERR_MASTER_PAR);
		if (err == ERR_MASTER_PAR) return;
		send_field(slave, 12, err == ERR_SLAVE_PAR);
		if (err == ERR_SLAVE_PAR) return;
		send_pulse(12'($urandom_range(4095, 0)));
		send_field({8'd0, ctrl}, 4, err == ERR_CTRL_PAR);
		if (err == ERR_CTRL_PAR) return;
		send_pulse(12'($urandom_range(4095, 0)));
		send_field(len[11:0], 8, err == ERR_LEN_PAR);
		if (err == ERR_LEN_PAR) return;
		send_pulse(12'($urandom_range(4095, 0)));
		if (err == ERR_TOO_LONG || len == 0) return;
		for (k = 0; k < len; k++) begin
			dbyte = (cur_zero_min == '0) ? 8'd0 : 8'($urandom_range(255, 0));
			send_field({4'd0, dbyte}, 8, err == ERR_DATA_PAR && k == bad_byte);
			if (err == ERR_DATA_PAR && k == bad_byte) return;
			send_pulse(12'($urandom_range(4095, 0)));
		end
	endtask

	// Stop offering pulses until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_OWN_ADDRESS:  cur_own       = value;
			CFG_BIT_ZERO_MIN: cur_zero_min  = value;
			CFG_START_MIN:    cur_start_min = value;
			default:          cur_max_len   = value[ByteW-1:0];
		endcase
	endtask

	// One register setting followed by a mix of frames and noise
	task automatic run_setting(input logic [11:0] own, input logic [11:0] zero_min,
			input logic [11:0] start_min, input logic [7:0] max_len, input int budget,
			input logic calm);
		int               stop_at;
		int               nframes;
		int               roll;
		int               len;
		logic [CodeW-1:0] err;
		drain();
		repeat (4) @(negedge clk);
		write_reg(CFG_OWN_ADDRESS, own);
		write_reg(CFG_BIT_ZERO_MIN, zero_min);
		write_reg(CFG_START_MIN, start_min);
		write_reg(CFG_MAX_LENGTH, {4'd0, max_len});
		steady <= calm;
		settings_done++;
		stop_at = pulses_sent + budget;
		nframes = 0;
		while (pulses_sent < stop_at) begin
			// long result hold-off while pulses keep coming
			if (!calm && nframes == 3)
				holdoff_req <= holdoff_req + 1;
			nframes++;
			roll = $urandom_range(99, 0);
			err  = ERR_NONE;
			len  = $urandom_range((cur_max_len < 6) ? cur_max_len : 6, 0);
			if (roll < 8)
				len = (cur_max_len > 16) ? 16 : cur_max_len;
			if (cur_zero_min == '0)
				len = 0;
			if (roll >= 62 && roll < 72 && cur_max_len != 8'hFF && cur_zero_min != '0) begin
				err = ERR_TOO_LONG;
				len = $urandom_range(255, cur_max_len + 1);
			end else if (roll >= 72 && roll < 90 && cur_zero_min != '0) begin
				case ($urandom_range(4, 0))
					0:       err = ERR_MASTER_PAR;
					1:       err = ERR_SLAVE_PAR;
					2:       err = ERR_CTRL_PAR;
					3:       err = ERR_LEN_PAR;
					default: err = ERR_DATA_PAR;
				endcase
				if (err == ERR_DATA_PAR && len == 0)
					len = 1;
			end
			if (roll >= 90) begin
				// noise: short starts, stray starts and partial frames
				repeat ($urandom_range(5, 1)) begin
					if (cur_start_min != '0 && $urandom_range(1, 0))
						send_pulse(12'($urandom_range(cur_start_min - 1, 0)));
					else
						send_pulse(12'($urandom_range(4095, 0)));
				end
			end else begin
				send_frame(err, len);
			end
			if ($urandom_range(99, 0) < 4)
				drain();
		end
	endtask

	// Stimulus and verdict
	initial begin
		int i;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		pulse_ticks   = '0;
		cfg_write_en  = 1'b0;
		cfg_index     = CFG_OWN_ADDRESS;
		cfg_data      = '0;
		steady        = 1'b0;
		holdoff_req   = 0;
		pulses_sent   = 0;
		frames_sent   = 0;
		settings_done = 0;
		cur_own       = OWN_ADDRESS_RST;
		cur_zero_min  = BIT_ZERO_MIN_RST;
		cur_start_min = START_MIN_RST;
		cur_max_len   = MAX_LENGTH_RST;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: short starts at zero and just under the limit, a start at
		// exactly the limit, then an all-ones master address with bad parity
		send_pulse(12'd0);
		send_pulse(START_MIN_RST - 12'd1);
		send_pulse(START_MIN_RST);
		send_pulse(BIT_ZERO_MIN_RST - 12'd1);
		for (i = 0; i < 12; i++)
			send_pulse((i % 2) ? 12'd0 : BIT_ZERO_MIN_RST - 12'd1);
		send_pulse(12'd0);
		send_pulse(BIT_ZERO_MIN_RST);

		// Random frames under several settings, extremes included
		run_setting(12'($urandom_range(4095, 0)), 12'd26, 12'd150, 8'd32, 280, 1'b0);
		run_setting(12'd0, 12'd0, 12'd0, 8'd0, 150, 1'b0);
		run_setting(12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 280, 1'b1);
		run_setting(12'($urandom_range(4095, 0)), 12'($urandom_range(400, 2)),
			12'($urandom_range(4095, 400)), 8'($urandom_range(20, 1)), 350, 1'b0);
		run_setting(12'($urandom_range(4095, 0)), 12'd1, 12'd1, 8'd8, 240, 1'b0);

		drain();
		repeat (10) @(negedge clk);
		$display("Sent %0d pulses (%0d frames) under %0d register settings;",
			pulses_sent, frames_sent, settings_done);
		$display("checked %0d results, %0d mismatches.", results_checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
design/iebus_pkg.sv
design/iebus_frame_receiver.sv
bench/iebus_frame_checker.sv
bench/tb_iebus_frame_receiver.sv
